// File: rtl/core/tcw_pkg.sv
// Shared constants for the text console writer: opcodes, control characters,
// register indexes, reset colors and the cell type. Has no dependencies.
package tcw_pkg;

  // Opcodes on the input channel
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Control and fill characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Register indexes, taken from the word address
  localparam logic REG_BACK = 1'b0;
  localparam logic REG_FORE = 1'b1;

  // Reset colors
  localparam logic [3:0] BACK_RESET = 4'h0;
  localparam logic [3:0] FORE_RESET = 4'h7;

  typedef logic [15:0] cell_t;

endpackage

// File: rtl/core/text_console_writer.sv
// Text console writer: screen store as a circular row buffer in one synchronous RAM.
// Set, read, NUL, newline and backspace pass through execute to done; a character also
//   writes one cell, a tab TAB spaces; clear blanks every cell, a scroll one row.
// One item at a time: no new transfer is taken until the result is posted.
// Reset: a clearing pass writes zero to all COLS*ROWS cells, one per cycle, taking no
//   input transfer meanwhile; configuration writes are taken as ever. Depends on tcw_pkg.
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  parameter int TAB  = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_code,
  input  logic [6:0]  column,
  input  logic [4:0]  row,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] cursor_pos,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_color
);

  localparam int NCELLS = COLS * ROWS;
  localparam int AW = $clog2(NCELLS);
  localparam int CW = $clog2(COLS);
  localparam int RW = $clog2(ROWS);
  localparam int TW = $clog2(TAB + 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_STORE  = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]    state;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [RW-1:0] top;
  logic [AW-1:0] sweep;
  logic [TW-1:0] tab_left;
  logic [1:0]    op_q;
  logic [7:0]    ch_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [3:0]    back_color;
  logic [3:0]    fore_color;

  tcw_pkg::cell_t mem [NCELLS];
  tcw_pkg::cell_t rdata;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  tcw_pkg::cell_t mem_wdata;
  logic           mem_re;

  logic [7:0]     attr;
  tcw_pkg::cell_t blank;
  logic           at_home;
  logic           wrap_col;
  logic           last_row;
  logic [CW-1:0]  bs_col;
  logic [RW-1:0]  bs_row;
  logic [CW-1:0]  sel_col;
  logic [RW-1:0]  sel_row;
  logic [RW:0]    prow_sum;
  logic [RW-1:0]  prow;
  logic [AW-1:0]  cell_addr;
  logic [CW-1:0]  col_clamp;
  logic [RW-1:0]  row_clamp;
  logic [AW-1:0]  pos_lin;
  logic [AW+10:0] pos_ext;
  logic [7:0]     store_ch;
  logic           cfg_wr;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign cfg_wr   = psel & penable & pwrite;

  // Read back configuration registers
  always_comb begin
    case (paddr[2])
      tcw_pkg::REG_FORE: prdata = {28'b0, fore_color};
      default:           prdata = {28'b0, back_color};
    endcase
  end

  assign attr  = {back_color, fore_color};
  assign blank = {attr, tcw_pkg::CH_SPACE};

  // Cursor conditions
  assign at_home  = (cur_col == '0) && (cur_row == '0);
  assign wrap_col = (cur_col == CW'(COLS - 1));
  assign last_row = (cur_row == RW'(ROWS - 1));
  assign bs_col   = (cur_col != '0) ? cur_col - 1'b1 : CW'(COLS - 1);
  assign bs_row   = (cur_col != '0) ? cur_row : cur_row - 1'b1;

  // Clamp incoming coordinates to the screen
  assign col_clamp = (32'(column) >= COLS) ? CW'(COLS - 1) : CW'(column);
  assign row_clamp = (32'(row) >= ROWS) ? RW'(ROWS - 1) : RW'(row);

  // Pick the logical cell to address this cycle
  always_comb begin
    sel_row = cur_row;
    sel_col = cur_col;
    if (state == S_EXEC && op_q == tcw_pkg::OP_READ) begin
      sel_row = row_q;
      sel_col = col_q;
    end else if (state == S_EXEC) begin
      sel_row = bs_row;
      sel_col = bs_col;
    end else if (state == S_SCROLL) begin
      // logical row 0 is the row that becomes the new bottom
      sel_row = '0;
      sel_col = sweep[CW-1:0];
    end
  end

  // Map logical row to physical row of the circular buffer
  assign prow_sum  = {1'b0, sel_row} + {1'b0, top};
  assign prow      = (prow_sum >= (RW+1)'(ROWS)) ? RW'(prow_sum - (RW+1)'(ROWS))
                                                 : prow_sum[RW-1:0];
  assign cell_addr = AW'(prow * COLS + sel_col);

  assign store_ch = (ch_q == tcw_pkg::CH_TAB) ? tcw_pkg::CH_SPACE : ch_q;

  // Drive the RAM write and read ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = blank;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep;
        mem_wdata = '0;
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep;
      end
      S_EXEC: begin
        mem_we = (op_q == tcw_pkg::OP_PUT) && (ch_q == tcw_pkg::CH_BS) && !at_home;
      end
      S_STORE: begin
        mem_we    = 1'b1;
        mem_wdata = {attr, store_ch};
      end
      S_SCROLL: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re = (state == S_EXEC) && (op_q == tcw_pkg::OP_READ);

  // Screen store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[cell_addr];
    end
  end

  // Linear cursor position, cut to the result width
  assign pos_lin = AW'(cur_row * COLS + cur_col);
  assign pos_ext = {11'b0, pos_lin};

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      sweep      <= '0;
      cur_col    <= '0;
      cur_row    <= '0;
      top        <= '0;
      tab_left   <= '0;
      out_valid  <= 1'b0;
      back_color <= tcw_pkg::BACK_RESET;
      fore_color <= tcw_pkg::FORE_RESET;
    end else begin
      // take configuration writes
      if (cfg_wr) begin
        case (paddr[2])
          tcw_pkg::REG_FORE: fore_color <= pwdata[3:0];
          default:           back_color <= pwdata[3:0];
        endcase
      end
      // drop the result once transferred, unless a new one is posted
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_INIT: begin
          if (sweep == AW'(NCELLS - 1)) begin
            sweep <= '0;
            state <= S_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_CLEAR: begin
          if (sweep == AW'(NCELLS - 1)) begin
            sweep <= '0;
            state <= S_DONE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= opcode;
            ch_q  <= char_code;
            col_q <= col_clamp;
            row_q <= row_clamp;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (op_q)
            tcw_pkg::OP_PUT: begin
              case (ch_q)
                tcw_pkg::CH_NUL: begin
                  state <= S_DONE;
                end
                tcw_pkg::CH_BS: begin
                  if (!at_home) begin
                    cur_col <= bs_col;
                    cur_row <= bs_row;
                  end
                  state <= S_DONE;
                end
                tcw_pkg::CH_LF: begin
                  cur_col <= '0;
                  if (last_row) begin
                    tab_left <= '0;
                    sweep    <= '0;
                    state    <= S_SCROLL;
                  end else begin
                    cur_row <= cur_row + 1'b1;
                    state   <= S_DONE;
                  end
                end
                tcw_pkg::CH_TAB: begin
                  tab_left <= TW'(TAB);
                  state    <= S_STORE;
                end
                default: begin
                  tab_left <= TW'(1);
                  state    <= S_STORE;
                end
              endcase
            end
            tcw_pkg::OP_SET: begin
              cur_col <= col_q;
              cur_row <= row_q;
              state   <= S_DONE;
            end
            tcw_pkg::OP_READ: begin
              state <= S_DONE;
            end
            default: begin
              cur_col <= '0;
              cur_row <= '0;
              top     <= '0;
              sweep   <= '0;
              state   <= S_CLEAR;
            end
          endcase
        end
        S_STORE: begin
          // cell is written this cycle; advance the cursor
          tab_left <= tab_left - 1'b1;
          if (wrap_col) begin
            cur_col <= '0;
            if (last_row) begin
              sweep <= '0;
              state <= S_SCROLL;
            end else begin
              cur_row <= cur_row + 1'b1;
              state   <= (tab_left == TW'(1)) ? S_DONE : S_STORE;
            end
          end else begin
            cur_col <= cur_col + 1'b1;
            state   <= (tab_left == TW'(1)) ? S_DONE : S_STORE;
          end
        end
        S_SCROLL: begin
          // blank the old top row, then rotate it to the bottom
          if (sweep == AW'(COLS - 1)) begin
            sweep <= '0;
            top   <= (top == RW'(ROWS - 1)) ? '0 : top + 1'b1;
            state <= (tab_left != '0) ? S_STORE : S_DONE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            cursor_pos <= pos_ext[10:0];
            if (op_q == tcw_pkg::OP_READ) begin
              cell_char  <= rdata[7:0];
              cell_color <= rdata[15:8];
            end else begin
              cell_char  <= '0;
              cell_color <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer, cursor and screen store ports
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("transfer did not start execution");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mem_we)
    else $error("screen write outside an operation");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_col) < COLS) && (32'(cur_row) < ROWS) && (32'(top) < ROWS))
    else $error("cursor or top row out of range");

  a_read_needs_op: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (state == S_EXEC) && !mem_we)
    else $error("screen read overlaps a write");

endmodule
